>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// shared types, token codes and character classes of the source text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

	typedef enum logic [4:0] {
		TOK_EOF       = 5'd0,
		TOK_IDENT     = 5'd1,
		TOK_NUMBER    = 5'd2,
		TOK_STRING    = 5'd3,
		TOK_KEYWORD   = 5'd4,
		TOK_PLUS      = 5'd5,
		TOK_MINUS     = 5'd6,
		TOK_MUL       = 5'd7,
		TOK_DIV       = 5'd8,
		TOK_ASSIGN    = 5'd9,
		TOK_EQ        = 5'd10,
		TOK_NE        = 5'd11,
		TOK_LT        = 5'd12,
		TOK_GT        = 5'd13,
		TOK_LE        = 5'd14,
		TOK_GE        = 5'd15,
		TOK_LPAREN    = 5'd16,
		TOK_RPAREN    = 5'd17,
		TOK_LBRACE    = 5'd18,
		TOK_RBRACE    = 5'd19,
		TOK_SEMI      = 5'd20,
		TOK_COMMA     = 5'd21,
		TOK_ERROR     = 5'd22
	} tok_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING,
		MODE_EQ,
		MODE_BANG,
		MODE_LT,
		MODE_GT
	} scan_mode_t;

	// one token as it leaves the block
	typedef struct packed {
		logic        last;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] column;
		logic [15:0] line;
		tok_kind_t   kind;
	} token_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam int KW_NUM   = 9;
	localparam int KW_CHARS = 6;

	// keyword text, first character in the lowest byte
	localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
		48'h0000_0074_656c,  // let
		48'h0000_0000_6669,  // if
		48'h0000_6573_6c65,  // else
		48'h0065_6c69_6877,  // while
		48'h0000_0072_6f66,  // for
		48'h6e72_7574_6572,  // return
		48'h0000_6575_7274,  // true
		48'h0065_736c_6166,  // false
		48'h0000_7469_7865   // exit
	};
	localparam logic [2:0] KW_LEN [KW_NUM] = '{
		3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd4, 3'd5, 3'd4
	};

	function automatic logic alpha_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic numeral_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0D;
	endfunction

	// mode entered when a byte arrives between tokens
	function automatic scan_mode_t start_mode(input logic [7:0] c);
		scan_mode_t m;
		case (c)
			"\"":    m = MODE_STRING;
			"=":     m = MODE_EQ;
			"!":     m = MODE_BANG;
			"<":     m = MODE_LT;
			">":     m = MODE_GT;
			default: m = alpha_char(c) ? MODE_IDENT :
			             numeral_char(c) ? MODE_NUMBER : MODE_IDLE;
		endcase
		return m;
	endfunction

	// kind of a byte that is a token of its own
	function automatic tok_kind_t single_kind(input logic [7:0] c);
		tok_kind_t k;
		case (c)
			"+":     k = TOK_PLUS;
			"-":     k = TOK_MINUS;
			"*":     k = TOK_MUL;
			"/":     k = TOK_DIV;
			"(":     k = TOK_LPAREN;
			")":     k = TOK_RPAREN;
			"{":     k = TOK_LBRACE;
			"}":     k = TOK_RBRACE;
			";":     k = TOK_SEMI;
			",":     k = TOK_COMMA;
			default: k = TOK_ERROR;
		endcase
		return k;
	endfunction

	// operator held back, completed by '='
	function automatic tok_kind_t pair_kind(input scan_mode_t m);
		tok_kind_t k;
		unique case (m)
			MODE_EQ:   k = TOK_EQ;
			MODE_BANG: k = TOK_NE;
			MODE_LT:   k = TOK_LE;
			default:   k = TOK_GE;
		endcase
		return k;
	endfunction

	// operator held back, ended by anything else
	function automatic tok_kind_t lone_kind(input scan_mode_t m);
		tok_kind_t k;
		unique case (m)
			MODE_EQ:   k = TOK_ASSIGN;
			MODE_LT:   k = TOK_LT;
			MODE_GT:   k = TOK_GT;
			default:   k = TOK_ERROR;
		endcase
		return k;
	endfunction

	// parallel compare of the first characters against all keywords;
	// len is the word length, 7 standing for anything longer than six
	function automatic logic kw_match(input logic [8*KW_CHARS-1:0] word,
	                                  input logic [2:0] len);
		logic [8*KW_CHARS-1:0] mask;
		logic                  hit;
		mask = '0;
		hit  = 1'b0;
		for (int j = 0; j < KW_CHARS; j++) begin
			if (3'(j) < len) begin
				mask[8*j +: 8] = 8'hFF;
			end
		end
		for (int i = 0; i < KW_NUM; i++) begin
			if (len == KW_LEN[i] && (word & mask) == KW_TEXT[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

>>> rtl/stt_scanner.sv
// ----------------------------------------------------------------------------
// stt_scanner
// scan state, position counters and the one-byte step that emits up to two tokens
// ----------------------------------------------------------------------------
module stt_scanner #(
	parameter int COUNT_BITS    = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output logic [1:0]        tok_valid,
	output stt_pkg::token_t   tok0,
	output stt_pkg::token_t   tok1
);
	import stt_pkg::*;

	localparam int PIW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] CNT_KW  = COUNT_BITS'(KEYWORD_CHARS);

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : COUNT_BITS'(v + CNT_ONE);
	endfunction

	function automatic logic [15:0] clamp16(input logic [COUNT_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	scan_mode_t              mode_q, mode_d;
	logic [COUNT_BITS-1:0]   line_q, col_q, off_q, scol_q, soff_q, len_q;
	logic [COUNT_BITS-1:0]   line_d, col_d, off_d, scol_d, soff_d, len_d;
	logic [7:0]              prefix_q [KEYWORD_CHARS];
	logic                    pw_en;
	logic [PIW-1:0]          pw_idx;

	// between-token scan of the current byte
	logic [COUNT_BITS-1:0]   id_line, id_col, id_off, id_scol, id_soff, id_len;
	logic                    id_emit, id_pw;
	token_t                  id_tok;

	// token held back by the current mode
	logic                    pend_valid;
	token_t                  pend_tok;
	logic [8*KW_CHARS-1:0]   word;
	logic [2:0]              word_len;

	logic                    go_idle;

	always_comb begin
		for (int j = 0; j < KW_CHARS; j++) begin
			word[8*j +: 8] = prefix_q[j];
		end
		word_len = (len_q <= COUNT_BITS'(KW_CHARS)) ? len_q[2:0] : 3'd7;
	end

	always_comb begin
		id_line = line_q;
		id_col  = sat_inc(col_q);
		id_off  = sat_inc(off_q);
		id_scol = scol_q;
		id_soff = soff_q;
		id_len  = len_q;
		id_emit = 1'b0;
		id_pw   = 1'b0;
		id_tok  = '{last: 1'b0, offset: clamp16(off_q), length: 16'd1,
		            column: clamp16(col_q), line: clamp16(line_q),
		            kind: single_kind(text_byte)};
		if (text_byte == 8'h0A) begin
			id_line = sat_inc(line_q);
			id_col  = CNT_ONE;
		end else if (is_blank(text_byte)) begin
			id_emit = 1'b0;
		end else if (start_mode(text_byte) != MODE_IDLE) begin
			id_scol = col_q;
			id_soff = off_q;
			id_len  = CNT_ONE;
			id_pw   = alpha_char(text_byte);
		end else begin
			id_emit = 1'b1;
		end
	end

	always_comb begin
		pend_valid = (mode_q != MODE_IDLE);
		pend_tok   = '{last: 1'b0, offset: clamp16(soff_q), length: clamp16(len_q),
		               column: clamp16(scol_q), line: clamp16(line_q), kind: TOK_IDENT};
		unique case (mode_q) inside
			MODE_IDENT:  pend_tok.kind = kw_match(word, word_len) ? TOK_KEYWORD : TOK_IDENT;
			MODE_NUMBER: pend_tok.kind = TOK_NUMBER;
			MODE_STRING: pend_tok.kind = TOK_STRING;
			MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
				pend_tok.kind   = lone_kind(mode_q);
				pend_tok.length = 16'd1;
			end
			default:     pend_tok.kind = TOK_IDENT;
		endcase
	end

	// next scan mode
	always_comb begin
		if (end_of_text) begin
			mode_d = MODE_IDLE;
		end else begin
			unique case (mode_q) inside
				MODE_IDENT:  mode_d = (alpha_char(text_byte) || numeral_char(text_byte)) ?
				                      MODE_IDENT : start_mode(text_byte);
				MODE_NUMBER: mode_d = numeral_char(text_byte) ? MODE_NUMBER :
				                      start_mode(text_byte);
				MODE_STRING: mode_d = (text_byte == "\"") ? MODE_IDLE : MODE_STRING;
				MODE_EQ, MODE_BANG, MODE_LT, MODE_GT:
				             mode_d = (text_byte == "=") ? MODE_IDLE : start_mode(text_byte);
				default:     mode_d = start_mode(text_byte);
			endcase
		end
	end

	// counters and emitted tokens
	always_comb begin
		line_d    = line_q;
		col_d     = col_q;
		off_d     = off_q;
		scol_d    = scol_q;
		soff_d    = soff_q;
		len_d     = len_q;
		pw_en     = 1'b0;
		pw_idx    = len_q[PIW-1:0];
		tok_valid = 2'b00;
		tok0      = pend_tok;
		tok1      = id_tok;
		go_idle   = 1'b0;
		if (end_of_text) begin
			tok_valid = {1'b1, pend_valid};
			tok1      = '{last: 1'b1, offset: clamp16(off_q), length: 16'd0,
			              column: clamp16(col_q), line: clamp16(line_q), kind: TOK_EOF};
			line_d    = CNT_ONE;
			col_d     = CNT_ONE;
			off_d     = '0;
			scol_d    = '0;
			soff_d    = '0;
			len_d     = '0;
		end else begin
			unique case (mode_q) inside
				MODE_IDENT: begin
					if (alpha_char(text_byte) || numeral_char(text_byte)) begin
						pw_en = (len_q < CNT_KW);
						len_d = sat_inc(len_q);
						col_d = sat_inc(col_q);
						off_d = sat_inc(off_q);
					end else begin
						go_idle = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (numeral_char(text_byte)) begin
						len_d = sat_inc(len_q);
						col_d = sat_inc(col_q);
						off_d = sat_inc(off_q);
					end else begin
						go_idle = 1'b1;
					end
				end
				MODE_STRING: begin
					len_d = sat_inc(len_q);
					off_d = sat_inc(off_q);
					if (text_byte == "\"") begin
						col_d     = sat_inc(col_q);
						tok_valid = 2'b10;
						tok1      = '{last: 1'b1, offset: clamp16(soff_q),
						              length: clamp16(sat_inc(len_q)), column: clamp16(scol_q),
						              line: clamp16(line_q), kind: TOK_STRING};
					end else if (text_byte == 8'h0A) begin
						line_d = sat_inc(line_q);
						col_d  = CNT_ONE;
					end else begin
						col_d = sat_inc(col_q);
					end
				end
				MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
					if (text_byte == "=") begin
						col_d     = sat_inc(col_q);
						off_d     = sat_inc(off_q);
						tok_valid = 2'b10;
						tok1      = '{last: 1'b1, offset: clamp16(soff_q), length: 16'd2,
						              column: clamp16(scol_q), line: clamp16(line_q),
						              kind: pair_kind(mode_q)};
					end else begin
						go_idle = 1'b1;
					end
				end
				default: go_idle = 1'b1;
			endcase
			if (go_idle) begin
				tok_valid = {id_emit, pend_valid};
				line_d    = id_line;
				col_d     = id_col;
				off_d     = id_off;
				scol_d    = id_scol;
				soff_d    = id_soff;
				len_d     = id_len;
				pw_en     = id_pw;
				pw_idx    = '0;
			end
		end
		tok0.last = !tok_valid[1];
		tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= CNT_ONE;
			col_q  <= CNT_ONE;
			off_q  <= '0;
			scol_q <= '0;
			soff_q <= '0;
			len_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
			off_q  <= off_d;
			scol_q <= scol_d;
			soff_q <= soff_d;
			len_q  <= len_d;
		end
	end

	// identifier prefix, only read at places written for the current word
	always_ff @(posedge clk) begin
		if (step && !end_of_text && pw_en) begin
			prefix_q[pw_idx] <= text_byte;
		end
	end

`ifndef NO_ASSERTIONS
	a_eof_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_text |-> tok_valid[1] && tok1.kind == TOK_EOF)
		else $error("end of text without eof token");

	a_counters_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_text |=> line_q == CNT_ONE && col_q == CNT_ONE && off_q == '0)
		else $error("counters not cleared after end of text");

	a_idle_no_flush: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q == MODE_IDLE |-> !tok_valid[0])
		else $error("flush token emitted with nothing pending");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(line_q) && $stable(off_q) && $stable(len_q))
		else $error("scan state moved without a step");
`endif

endmodule

>>> rtl/stt_tok_fifo.sv
// ----------------------------------------------------------------------------
// stt_tok_fifo
// small token queue: takes up to two tokens a cycle, hands out one
// ----------------------------------------------------------------------------
module stt_tok_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push,
	input  stt_pkg::token_t din0,
	input  stt_pkg::token_t din1,
	output logic            room,
	output logic            valid,
	input  logic            ready,
	output stt_pkg::token_t dout
);
	import stt_pkg::*;

	token_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wp_q, rp_q, wp1;
	logic [FIFO_CNT_W-1:0]   cnt_q;
	logic                    pop;

	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rp_q];
	assign pop   = valid && ready;
	// space for the worst case of two tokens from one byte
	assign room  = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign wp1   = wp_q + FIFO_PTR_W'(push[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_PTR_W'(push[0]) + FIFO_PTR_W'(push[1]);
			rp_q  <= rp_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push[0]) + FIFO_CNT_W'(push[1]) - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push[0]) begin
			mem_q[wp_q] <= din0;
		end
		if (push[1]) begin
			mem_q[wp1] <= din1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("token queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push != 2'b00 |-> room)
		else $error("push into queue without room");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push == 2'b00 && !pop |=> $stable(cnt_q))
		else $error("queue count moved without push or pop");
`endif

endmodule

>>> rtl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// streaming lexer: source bytes in, tokens with kind and position out
// ----------------------------------------------------------------------------
// usage
// input stream: one source byte per request in s_axis_tdata[7:0]; s_axis_tlast
// marks end of text (the byte is then ignored), which flushes any pending token,
// emits an eof token and puts line, column and offset back to their start values.
// output stream: one token per request; m_axis_tlast is set on the last token
// caused by an input byte. identifiers, numbers and < > = ! are held until the
// byte that ends them, so a token leaves with the following byte.
// path: a byte is held in the input register, is scanned and its tokens are
// written to a four-entry token queue, from whose head they are offered.
// one byte per cycle is sustained while the queue has room; a byte that both
// closes a pending token and emits its own puts two tokens in the queue, which
// hands them out one at a time through its single read port.
// stall: while the queue has less than two free entries, the scan step waits and
// s_axis_tready drops once the input register is full; nothing is lost.
// reset: arst_n clears the scan state, counters and queue; line and column start at 1.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
	parameter int COUNT_BITS    = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // text_byte
	input  logic        s_axis_tlast,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // token_kind[4:0], token_line[20:5],
	                                    // token_column[36:21], token_length[52:37],
	                                    // token_offset[68:53], zero fill
	output logic        m_axis_tlast    // last_of_run
);
	import stt_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;
	logic        room;
	logic        step;
	logic [1:0]  tok_valid;
	token_t      tok0, tok1, head;

	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eot_s1  <= s_axis_tlast;
		end
	end

	stt_scanner #(
		.COUNT_BITS    (COUNT_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_scanner (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.tok_valid   (tok_valid),
		.tok0        (tok0),
		.tok1        (tok1)
	);

	stt_tok_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_valid & {2{step}}),
		.din0   (tok0),
		.din1   (tok1),
		.room   (room),
		.valid  (m_axis_tvalid),
		.ready  (m_axis_tready),
		.dout   (head)
	);

	assign m_axis_tdata = {3'b000, head.offset, head.length, head.column, head.line,
	                       head.kind};
	assign m_axis_tlast = head.last;

`ifndef NO_ASSERTIONS
	a_input_reg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(eot_s1))
		else $error("input register lost a byte while waiting");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("not ready with an empty input register");

	a_eof_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		step && eot_s1 |=> m_axis_tvalid)
		else $error("end of text left no token in the queue");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for source_text_tokenizer: source bytes go in on the
// input stream and every token that comes out is compared with a lexer model
// kept in the bench. The run has a short directed part and a random token mix
// with idle gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import stt_pkg::*;

	localparam int RANDOM_BYTES = 575;
	localparam int HOLD_CYCLES  = 300;

	// tracks the lexer state and holds the tokens still owed by the block
	class token_checker;
		scan_mode_t  mode;
		logic [15:0] line_no, col_no, offs;
		logic [15:0] tok_col, tok_off, tok_len;
		logic [7:0]  word [6];
		token_t      tokens_due [$];
		int          errors;
		int          n_checked;

		function new();
			clear_counters();
			foreach (word[j]) word[j] = 8'h00;
			errors    = 0;
			n_checked = 0;
		endfunction

		function void clear_counters();
			mode    = MODE_IDLE;
			line_no = 16'd1;
			col_no  = 16'd1;
			offs    = 16'd0;
			tok_col = 16'd0;
			tok_off = 16'd0;
			tok_len = 16'd0;
		endfunction

		function logic [15:0] bump(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
		endfunction

		function bit digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function void add(tok_kind_t k, logic [15:0] ln, logic [15:0] col,
		                  logic [15:0] len, logic [15:0] off);
			token_t t;
			t.kind   = k;
			t.line   = ln;
			t.column = col;
			t.length = len;
			t.offset = off;
			t.last   = 1'b0;
			tokens_due.push_back(t);
		endfunction

		// words never hold a zero byte, so zero-extended literals cannot alias
		function bit reserved_word();
			logic [47:0] w;
			if (tok_len > 16'd6) return 1'b0;
			w = '0;
			for (int j = 0; j < tok_len; j++) w = {w[39:0], word[j]};
			case (w)
				"let", "if", "else", "while", "for", "return", "true", "false", "exit":
					return 1'b1;
				default:
					return 1'b0;
			endcase
		endfunction

		function void step();
			col_no = bump(col_no);
			offs   = bump(offs);
		endfunction

		function void newline();
			line_no = bump(line_no);
			col_no  = 16'd1;
			offs    = bump(offs);
		endfunction

		function void close_pending();
			case (mode)
				MODE_IDENT:  add(reserved_word() ? TOK_KEYWORD : TOK_IDENT,
				                 line_no, tok_col, tok_len, tok_off);
				MODE_NUMBER: add(TOK_NUMBER, line_no, tok_col, tok_len, tok_off);
				MODE_STRING: add(TOK_STRING, line_no, tok_col, tok_len, tok_off);
				MODE_EQ:     add(TOK_ASSIGN, line_no, tok_col, 16'd1, tok_off);
				MODE_BANG:   add(TOK_ERROR, line_no, tok_col, 16'd1, tok_off);
				MODE_LT:     add(TOK_LT, line_no, tok_col, 16'd1, tok_off);
				MODE_GT:     add(TOK_GT, line_no, tok_col, 16'd1, tok_off);
				default: ;
			endcase
			mode = MODE_IDLE;
		endfunction

		function void open(scan_mode_t m);
			mode    = m;
			tok_col = col_no;
			tok_off = offs;
			tok_len = 16'd1;
			step();
		endfunction

		function void scan_idle(logic [7:0] c);
			tok_kind_t k;
			if (c == " " || c == 8'h09 || c == 8'h0D) begin
				step();
				return;
			end
			if (c == 8'h0A) begin
				newline();
				return;
			end
			case (c)
				"+": k = TOK_PLUS;
				"-": k = TOK_MINUS;
				"*": k = TOK_MUL;
				"/": k = TOK_DIV;
				"(": k = TOK_LPAREN;
				")": k = TOK_RPAREN;
				"{": k = TOK_LBRACE;
				"}": k = TOK_RBRACE;
				";": k = TOK_SEMI;
				",": k = TOK_COMMA;
				"\"": begin
					open(MODE_STRING);
					return;
				end
				"=": begin
					open(MODE_EQ);
					return;
				end
				"!": begin
					open(MODE_BANG);
					return;
				end
				"<": begin
					open(MODE_LT);
					return;
				end
				">": begin
					open(MODE_GT);
					return;
				end
				default: begin
					if (letter(c)) begin
						word[0] = c;
						open(MODE_IDENT);
						return;
					end
					if (digit(c)) begin
						open(MODE_NUMBER);
						return;
					end
					k = TOK_ERROR;
				end
			endcase
			add(k, line_no, col_no, 16'd1, offs);
			step();
		endfunction

		// works out the tokens caused by one accepted request
		function void note_byte(logic [7:0] c, logic eot);
			int        n_before;
			tok_kind_t k;
			n_before = tokens_due.size();
			if (eot) begin
				close_pending();
				add(TOK_EOF, line_no, col_no, 16'd0, offs);
				clear_counters();
			end else begin
				case (mode)
					MODE_IDENT: begin
						if (letter(c) || digit(c)) begin
							if (tok_len < 16'd6) word[tok_len[2:0]] = c;
							tok_len = bump(tok_len);
							step();
						end else begin
							close_pending();
							scan_idle(c);
						end
					end
					MODE_NUMBER: begin
						if (digit(c)) begin
							tok_len = bump(tok_len);
							step();
						end else begin
							close_pending();
							scan_idle(c);
						end
					end
					MODE_STRING: begin
						tok_len = bump(tok_len);
						if (c == "\"") begin
							step();
							add(TOK_STRING, line_no, tok_col, tok_len, tok_off);
							mode = MODE_IDLE;
						end else if (c == 8'h0A) begin
							newline();
						end else begin
							step();
						end
					end
					MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
						if (c == "=") begin
							k = (mode == MODE_EQ) ? TOK_EQ :
							    (mode == MODE_BANG) ? TOK_NE :
							    (mode == MODE_LT) ? TOK_LE : TOK_GE;
							add(k, line_no, tok_col, 16'd2, tok_off);
							step();
							mode = MODE_IDLE;
						end else begin
							close_pending();
							scan_idle(c);
						end
					end
					default: begin
						mode = MODE_IDLE;
						scan_idle(c);
					end
				endcase
			end
			if (tokens_due.size() > n_before) tokens_due[tokens_due.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("mismatch: %s", msg);
		endtask

		task check_token(logic [71:0] d, logic lst);
			token_t e;
			if (tokens_due.size() == 0) begin
				report($sformatf("token of kind %0d with none outstanding", d[4:0]));
				return;
			end
			e = tokens_due.pop_front();
			n_checked++;
			if (d[4:0] !== e.kind)
				report($sformatf("token %0d kind %0d, expected %s", n_checked, d[4:0],
				                 e.kind.name()));
			if (d[20:5] !== e.line)
				report($sformatf("token %0d line %0d, expected %0d", n_checked, d[20:5],
				                 e.line));
			if (d[36:21] !== e.column)
				report($sformatf("token %0d column %0d, expected %0d", n_checked, d[36:21],
				                 e.column));
			if (d[52:37] !== e.length)
				report($sformatf("token %0d length %0d, expected %0d", n_checked, d[52:37],
				                 e.length));
			if (d[68:53] !== e.offset)
				report($sformatf("token %0d offset %0d, expected %0d", n_checked, d[68:53],
				                 e.offset));
			if (lst !== e.last)
				report($sformatf("token %0d last %b, expected %b", n_checked, lst, e.last));
		endtask

		function int pending();
			return tokens_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tlast;

	token_checker sb;
	int           n_sent;
	int           n_eot;
	bit           held_off;

	source_text_tokenizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	function automatic string keyword_text(int i);
		case (i)
			0:       return "let";
			1:       return "if";
			2:       return "else";
			3:       return "while";
			4:       return "for";
			5:       return "return";
			6:       return "true";
			7:       return "false";
			default: return "exit";
		endcase
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		return "_";
	endfunction

	function automatic logic [7:0] rand_word_char();
		if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
		return rand_letter();
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		// every fifth window of 80 requests runs without gaps
		gap = (((n_sent / 80) % 5) == 4) ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eot;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b, eot);
		n_sent++;
		if (eot) n_eot++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	// one lexical piece: mostly well-formed tokens, some whitespace and noise
	task automatic send_piece();
		int    r;
		int    n;
		string s;
		string ops;
		logic [7:0] v;
		ops = "+-*/(){};,=<>!";
		r   = $urandom_range(0, 99);
		if (r < 24) begin
			if ($urandom_range(0, 1) == 0) begin
				s = keyword_text($urandom_range(0, 8));
				n = s.len();
				if ($urandom_range(0, 4) == 0) n = n - 1;
				for (int i = 0; i < n; i++) send_byte(s[i], 1'b0);
				if ($urandom_range(0, 3) == 0) send_byte(rand_word_char(), 1'b0);
			end else begin
				send_byte(rand_letter(), 1'b0);
				repeat ($urandom_range(0, 9)) send_byte(rand_word_char(), 1'b0);
			end
		end else if (r < 36) begin
			repeat ($urandom_range(1, 6)) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
		end else if (r < 46) begin
			send_byte("\"", 1'b0);
			repeat ($urandom_range(0, 8)) begin
				v = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 5) == 0) v = 8'h0A;
				if (v == "\"") v = "a";
				send_byte(v, 1'b0);
			end
			if ($urandom_range(0, 9) != 0) send_byte("\"", 1'b0);
		end else if (r < 66) begin
			n = $urandom_range(0, 17);
			case (n)
				14:      send_text("==");
				15:      send_text("!=");
				16:      send_text("<=");
				17:      send_text(">=");
				default: send_byte(ops[n], 1'b0);
			endcase
		end else if (r < 86) begin
			case ($urandom_range(0, 3))
				0:       send_byte(" ", 1'b0);
				1:       send_byte(8'h09, 1'b0);
				2:       send_byte(8'h0D, 1'b0);
				default: send_byte(8'h0A, 1'b0);
			endcase
		end else if (r < 97) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// output side: random stalls, calm stretches and one long hold-off
	initial begin
		int stall_left;
		int gap;
		logic ready;
		stall_left    = 0;
		held_off      = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held_off && sb.n_checked >= 120) begin
				held_off      = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (stall_left > 0) begin
				ready = 1'b0;
				stall_left--;
			end else if (((sb.n_checked / 50) % 4) == 3) begin
				ready = 1'b1;
			end else begin
				gap = pick_gap();
				ready      = (gap == 0);
				stall_left = (gap > 0) ? gap - 1 : 0;
			end
			m_axis_tready <= ready;
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin
		#20ms;
		$display("timeout with %0d tokens outstanding", sb.pending());
		$display("FAILURE");
		$finish;
	end

	initial begin
		int stop_at;
		sb            = new();
		n_sent        = 0;
		n_eot         = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray zero and all-ones bytes
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// lone bang, then <= and a pending > flushed by end of text
		send_text("!x<=>");
		send_byte(8'h00, 1'b1);
		// unterminated string with a zero byte and a newline inside
		send_text("\"");
		send_byte(8'h00, 1'b0);
		send_byte(8'h0A, 1'b0);
		send_byte(8'hFF, 1'b1);
		// pending assign and pending bang at end of text
		send_text("=");
		send_byte(8'h00, 1'b1);
		send_text("!");
		send_byte(8'h00, 1'b1);
		send_text("for(7)if");
		send_byte(8'h00, 1'b1);

		stop_at = n_sent + RANDOM_BYTES;
		while (n_sent < stop_at) send_piece();
		send_byte(8'h00, 1'b1);
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("run: %0d bytes with %0d end-of-text marks, %0d tokens checked, %0d errors",
		         n_sent, n_eot, sb.n_checked, sb.errors);
		$display("covered: stray bytes, tokens pending at end of text, random token mix, %s",
		         $sformatf("%0d-cycle output hold-off", HOLD_CYCLES));
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
